FILE: design/rcss_pkg.sv
package rcss_pkg;

  localparam int unsigned FREQ_W   = 20;
  localparam int unsigned CODE_W   = 12;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned SETTLE_W = 10;
  localparam int unsigned TICK_W   = 8;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  // Phase two comes on at one stagger interval, phase three at two (range 1..127)
  localparam logic [TICK_W-1:0] STAGGER_TICKS = 8'd100;
  localparam logic [TICK_W-1:0] STAGGER_TWICE = TICK_W'(2 * STAGGER_TICKS);
  localparam logic [TICK_W-1:0] TICK_MAX      = '1;

  localparam logic [FREQ_W-1:0]   START_FREQ_RST  = 20'd300000;
  localparam logic [FREQ_W-1:0]   FLOOR_FREQ_RST  = 20'd100000;
  localparam logic [CODE_W-1:0]   WIN_LOW_RST     = 12'd0;
  localparam logic [CODE_W-1:0]   WIN_HIGH_RST    = 12'd4095;
  localparam logic [CODE_W-1:0]   OV_LIMIT_RST    = 12'd4095;
  localparam logic [CODE_W-1:0]   OC_LIMIT_RST    = 12'd4095;
  localparam logic [STEP_W-1:0]   RAMP_STEP_RST   = 16'd2000;
  localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 10'd50;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_BEGIN = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_LIMIT = 2'd1,
    FAULT_FLOOR = 2'd2
  } fault_t;

  typedef enum logic [2:0] {
    REG_START_FREQ   = 3'd0,
    REG_FLOOR_FREQ   = 3'd1,
    REG_WIN_LOW      = 3'd2,
    REG_WIN_HIGH     = 3'd3,
    REG_OV_LIMIT     = 3'd4,
    REG_OC_LIMIT     = 3'd5,
    REG_RAMP_STEP    = 3'd6,
    REG_SETTLE_TICKS = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [FREQ_W-1:0]   start_frequency;
    logic [FREQ_W-1:0]   floor_frequency;
    logic [CODE_W-1:0]   window_low;
    logic [CODE_W-1:0]   window_high;
    logic [CODE_W-1:0]   overvoltage_limit;
    logic [CODE_W-1:0]   overcurrent_limit;
    logic [STEP_W-1:0]   ramp_step;
    logic [SETTLE_W-1:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic              op;
    logic [CODE_W-1:0] voltage_sample;
    logic [CODE_W-1:0] current_sample;
  } item_t;

  typedef struct packed {
    logic [FREQ_W-1:0] frequency_command;
    logic              phase_one_on;
    logic              phase_two_on;
    logic              phase_three_on;
    logic              relay_closed;
    logic              converter_stopped;
    logic              done_res;
    logic [1:0]        fault_code;
  } res_t;

  typedef struct packed {
    logic [TICK_W-1:0]   tick_counter;
    logic [FREQ_W-1:0]   frequency;
    logic [SETTLE_W-1:0] settle_counter;
    logic [2:0]          phase_flags;
    logic                contactor_flag;
    logic                complete_flag;
    fault_t              fault_latch;
  } seq_state_t;

endpackage

FILE: design/rcss_if.sv
interface rcss_in_if import rcss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [CODE_W-1:0] voltage_sample;
  logic [CODE_W-1:0] current_sample;

  modport source (output valid, output op, output voltage_sample, output current_sample,
                  input ready);
  modport sink   (input valid, input op, input voltage_sample, input current_sample,
                  output ready);
endinterface

interface rcss_out_if import rcss_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FREQ_W-1:0] frequency_command;
  logic              phase_one_on;
  logic              phase_two_on;
  logic              phase_three_on;
  logic              relay_closed;
  logic              converter_stopped;
  logic              done_res;
  logic [1:0]        fault_code;

  modport source (output valid, output frequency_command, output phase_one_on,
                  output phase_two_on, output phase_three_on, output relay_closed,
                  output converter_stopped, output done_res, output fault_code,
                  input ready);
  modport sink   (input valid, input frequency_command, input phase_one_on,
                  input phase_two_on, input phase_three_on, input relay_closed,
                  input converter_stopped, input done_res, input fault_code,
                  output ready);
endinterface

FILE: design/rcss_cfg_regs.sv
module rcss_cfg_regs import rcss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_START_FREQ:   cfg_nxt.start_frequency   = pwdata[FREQ_W-1:0];
        REG_FLOOR_FREQ:   cfg_nxt.floor_frequency   = pwdata[FREQ_W-1:0];
        REG_WIN_LOW:      cfg_nxt.window_low        = pwdata[CODE_W-1:0];
        REG_WIN_HIGH:     cfg_nxt.window_high       = pwdata[CODE_W-1:0];
        REG_OV_LIMIT:     cfg_nxt.overvoltage_limit = pwdata[CODE_W-1:0];
        REG_OC_LIMIT:     cfg_nxt.overcurrent_limit = pwdata[CODE_W-1:0];
        REG_RAMP_STEP:    cfg_nxt.ramp_step         = pwdata[STEP_W-1:0];
        REG_SETTLE_TICKS: cfg_nxt.settle_ticks      = pwdata[SETTLE_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_START_FREQ:   prdata = PDATA_W'(cfg_r.start_frequency);
      REG_FLOOR_FREQ:   prdata = PDATA_W'(cfg_r.floor_frequency);
      REG_WIN_LOW:      prdata = PDATA_W'(cfg_r.window_low);
      REG_WIN_HIGH:     prdata = PDATA_W'(cfg_r.window_high);
      REG_OV_LIMIT:     prdata = PDATA_W'(cfg_r.overvoltage_limit);
      REG_OC_LIMIT:     prdata = PDATA_W'(cfg_r.overcurrent_limit);
      REG_RAMP_STEP:    prdata = PDATA_W'(cfg_r.ramp_step);
      REG_SETTLE_TICKS: prdata = PDATA_W'(cfg_r.settle_ticks);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_frequency   <= START_FREQ_RST;
      cfg_r.floor_frequency   <= FLOOR_FREQ_RST;
      cfg_r.window_low        <= WIN_LOW_RST;
      cfg_r.window_high       <= WIN_HIGH_RST;
      cfg_r.overvoltage_limit <= OV_LIMIT_RST;
      cfg_r.overcurrent_limit <= OC_LIMIT_RST;
      cfg_r.ramp_step         <= RAMP_STEP_RST;
      cfg_r.settle_ticks      <= SETTLE_TICKS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: design/rcss_seq.sv
module rcss_seq import rcss_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step_en,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  seq_state_t st_r, st_nxt;

  // Next state for one item
  always_comb begin
    logic [TICK_W-1:0] tc;
    logic              limit_hit;
    logic              in_window;
    logic [FREQ_W:0]   floor_sum;

    st_nxt    = st_r;
    tc        = '0;
    limit_hit = 1'b0;
    in_window = 1'b0;
    floor_sum = '0;

    if (item.op == OP_BEGIN) begin
      st_nxt.tick_counter   = '0;
      st_nxt.frequency      = cfg.start_frequency;
      st_nxt.settle_counter = cfg.settle_ticks;
      st_nxt.phase_flags    = 3'b001;
      st_nxt.contactor_flag = 1'b0;
      st_nxt.complete_flag  = 1'b0;
      st_nxt.fault_latch    = FAULT_NONE;
    end else if (!st_r.complete_flag) begin
      tc = (st_r.tick_counter != TICK_MAX) ? st_r.tick_counter + 1'b1 : st_r.tick_counter;
      st_nxt.tick_counter = tc;
      if (tc == STAGGER_TICKS) st_nxt.phase_flags[1] = 1'b1;
      if (tc == STAGGER_TWICE) st_nxt.phase_flags[2] = 1'b1;

      limit_hit = (item.voltage_sample > cfg.overvoltage_limit) ||
                  (item.current_sample > cfg.overcurrent_limit);
      in_window = (item.voltage_sample >= cfg.window_low) &&
                  (item.voltage_sample <= cfg.window_high);
      floor_sum = {1'b0, cfg.floor_frequency} + {{(FREQ_W+1-STEP_W){1'b0}}, cfg.ramp_step};

      priority if (limit_hit) begin
        st_nxt.complete_flag = 1'b1;
        st_nxt.fault_latch   = FAULT_LIMIT;
      end else if (st_nxt.phase_flags != 3'b111) begin
        st_nxt.complete_flag = st_r.complete_flag;
      end else if (st_r.settle_counter != '0) begin
        st_nxt.settle_counter = st_r.settle_counter - 1'b1;
      end else if (in_window) begin
        st_nxt.contactor_flag = 1'b1;
        st_nxt.complete_flag  = 1'b1;
      end else if ({1'b0, st_r.frequency} <= floor_sum) begin
        st_nxt.complete_flag = 1'b1;
        st_nxt.fault_latch   = FAULT_FLOOR;
      end else begin
        st_nxt.frequency      = st_r.frequency - FREQ_W'(cfg.ramp_step);
        st_nxt.settle_counter = cfg.settle_ticks;
      end
    end
  end

  // Result reflects the state after this item
  always_comb begin
    res.frequency_command = st_nxt.frequency;
    res.phase_one_on      = st_nxt.phase_flags[0];
    res.phase_two_on      = st_nxt.phase_flags[1];
    res.phase_three_on    = st_nxt.phase_flags[2];
    res.relay_closed      = st_nxt.contactor_flag;
    res.converter_stopped = st_nxt.complete_flag && (st_nxt.fault_latch != FAULT_NONE);
    res.done_res          = st_nxt.complete_flag;
    res.fault_code        = st_nxt.fault_latch;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.tick_counter   <= '0;
      st_r.frequency      <= '0;
      st_r.settle_counter <= '0;
      st_r.phase_flags    <= '0;
      st_r.contactor_flag <= 1'b0;
      st_r.complete_flag  <= 1'b0;
      st_r.fault_latch    <= FAULT_NONE;
    end else if (step_en) begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: design/resonant_converter_soft_start.sv
// Soft-start sequencer for a three-phase resonant converter.
// Input channel in_ch: one transaction per 1 ms tick (op = tick) carrying the
// output voltage and current ADC codes, or a begin transaction (op = begin)
// that restarts the sequence from the start frequency with phase one on.
// Result channel out_ch: exactly one transaction per input transaction, in
// order, giving frequency command, phase enables, contactor, stop, done and
// fault code as they stand after that input.
// Configuration: APB-style write/read port, register i at byte address 4*i;
// to be written only while the block is idle; the block has no such check.
// Path: input acceptance into the input register, then the sequencer step
// into the result register.
// Throughput: one transaction per cycle unless stalled; the step is a few
// compares, one 21-bit add and a 20-bit subtract, all between the registers.
// Reset (rst_n low, synchronous): pipeline empties, sequencer state clears
// to frequency zero with all phases off, registers take their defaults.
// Receiver stall: the result register holds; the input register still takes
// a transaction while it is empty, then input ready drops until the result
// is taken.
module resonant_converter_soft_start import rcss_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  rcss_in_if.sink            in_ch,
  rcss_out_if.source         out_ch,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  cfg_t  cfg;
  item_t item_r;
  res_t  res_step;
  res_t  res_r;
  logic  in_vld_r, in_vld_nxt;
  logic  out_vld_r, out_vld_nxt;
  logic  advance;
  logic  in_take;

  rcss_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Held item moves on when the result register is free or being emptied
  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  // Sequencer state steps exactly once per transaction
  rcss_seq u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res_step)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op             <= in_ch.op;
      item_r.voltage_sample <= in_ch.voltage_sample;
      item_r.current_sample <= in_ch.current_sample;
    end
    if (advance) begin
      res_r <= res_step;
    end
  end

  assign out_ch.valid             = out_vld_r;
  assign out_ch.frequency_command = res_r.frequency_command;
  assign out_ch.phase_one_on      = res_r.phase_one_on;
  assign out_ch.phase_two_on      = res_r.phase_two_on;
  assign out_ch.phase_three_on    = res_r.phase_three_on;
  assign out_ch.relay_closed      = res_r.relay_closed;
  assign out_ch.converter_stopped = res_r.converter_stopped;
  assign out_ch.done_res          = res_r.done_res;
  assign out_ch.fault_code        = res_r.fault_code;

endmodule

FILE: design/rcss_checker.sv
module rcss_checker import rcss_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [FREQ_W-1:0] frequency_command,
  input logic              phase_three_on,
  input logic              relay_closed,
  input logic              converter_stopped,
  input logic              done_res,
  input logic [1:0]        fault_code
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(frequency_command) &&
                                $stable(done_res) && $stable(fault_code))
    else $error("stalled result changed");

  a_stop_is_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && converter_stopped |-> done_res && fault_code != FAULT_NONE)
    else $error("stop without latched fault");

  a_contactor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && relay_closed |-> done_res && fault_code == FAULT_NONE &&
                                  phase_three_on)
    else $error("contactor closed in a bad state");

  a_floor_all_phases: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && fault_code == FAULT_FLOOR |-> phase_three_on && done_res)
    else $error("floor fault before all phases on");

endmodule

bind resonant_converter_soft_start rcss_checker u_rcss_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .frequency_command (out_ch.frequency_command),
  .phase_three_on    (out_ch.phase_three_on),
  .relay_closed      (out_ch.relay_closed),
  .converter_stopped (out_ch.converter_stopped),
  .done_res          (out_ch.done_res),
  .fault_code        (out_ch.fault_code)
);

FILE: test/resonant_converter_soft_start_test.sv
`timescale 1ns / 1ps

module resonant_converter_soft_start_test import rcss_pkg::*; ();

  localparam int HOLD_OFF_CYCLES = 60;  // long receiver hold-off, fills the pipeline
  localparam int DRAIN_CYCLES    = 8;   // well beyond the input-to-result latency
  localparam int MAX_REPORTS     = 10;
  localparam int CODE_MAX        = 4095;

  logic clk = 1'b0;
  logic rst_n;

  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  rcss_in_if  in_ch ();
  rcss_out_if out_ch ();

  resonant_converter_soft_start i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Shadow copy of the registers and of the sequencer state; the predictor
  // below works on these alone.
  cfg_t       reg_shadow;
  seq_state_t seq;
  res_t       status_expected[$];

  // Idling controls for the sender and the receiver process
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;

  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int reg_writes      = 0;
  int closes_seen     = 0;
  int limit_aborts    = 0;
  int floor_faults    = 0;
  int saturations     = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One millisecond tick while the sequence is still running.
  function automatic void apply_tick(logic [CODE_W-1:0] v, logic [CODE_W-1:0] i);
    logic [FREQ_W:0] floor_sum;
    if (seq.tick_counter != TICK_MAX) begin
      seq.tick_counter = seq.tick_counter + 1'b1;
      if (seq.tick_counter == TICK_MAX) saturations++;
    end
    // stagger: phase two at one interval, phase three at two
    if (seq.tick_counter == STAGGER_TICKS) seq.phase_flags[1] = 1'b1;
    if (seq.tick_counter == STAGGER_TWICE) seq.phase_flags[2] = 1'b1;

    // safety check comes before every other decision; phase flags are left as they are
    if (v > reg_shadow.overvoltage_limit || i > reg_shadow.overcurrent_limit) begin
      seq.complete_flag = 1'b1;
      seq.fault_latch   = FAULT_LIMIT;
      return;
    end
    if (seq.phase_flags != 3'b111) return;
    if (seq.settle_counter != '0) begin
      seq.settle_counter = seq.settle_counter - 1'b1;
      return;
    end
    // an empty window (low above high) never matches
    if (v >= reg_shadow.window_low && v <= reg_shadow.window_high) begin
      seq.contactor_flag = 1'b1;
      seq.complete_flag  = 1'b1;
      return;
    end
    // floor plus one step, formed one bit wider so it cannot wrap
    floor_sum = {1'b0, reg_shadow.floor_frequency} + reg_shadow.ramp_step;
    if ({1'b0, seq.frequency} <= floor_sum) begin
      seq.complete_flag = 1'b1;
      seq.fault_latch   = FAULT_FLOOR;
      return;
    end
    seq.frequency      = seq.frequency - reg_shadow.ramp_step;
    seq.settle_counter = reg_shadow.settle_ticks;
  endfunction

  function automatic res_t predict_status(item_t it);
    res_t r;
    if (it.op == OP_BEGIN) begin
      // begin restarts from scratch whatever the state; samples are ignored
      seq                = '0;
      seq.frequency      = reg_shadow.start_frequency;
      seq.settle_counter = reg_shadow.settle_ticks;
      seq.phase_flags    = 3'b001;
    end else if (!seq.complete_flag) begin
      apply_tick(it.voltage_sample, it.current_sample);
      if (seq.complete_flag) begin
        case (seq.fault_latch)
          FAULT_NONE:  closes_seen++;
          FAULT_LIMIT: limit_aborts++;
          default:     floor_faults++;
        endcase
      end
    end
    r.frequency_command = seq.frequency;
    r.phase_one_on      = seq.phase_flags[0];
    r.phase_two_on      = seq.phase_flags[1];
    r.phase_three_on    = seq.phase_flags[2];
    r.relay_closed      = seq.contactor_flag;
    r.converter_stopped = seq.complete_flag && (seq.fault_latch != FAULT_NONE);
    r.done_res          = seq.complete_flag;
    r.fault_code        = seq.fault_latch;
    return r;
  endfunction

  task automatic note_mismatch(string what, res_t want, res_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: exp f=%0d ph=%b%b%b rly=%b stop=%b done=%b flt=%0d",
               $time, what,
               want.frequency_command, want.phase_one_on, want.phase_two_on,
               want.phase_three_on, want.relay_closed, want.converter_stopped,
               want.done_res, want.fault_code);
      $display("%0t %s: got f=%0d ph=%b%b%b rly=%b stop=%b done=%b flt=%0d",
               $time, what,
               got.frequency_command, got.phase_one_on, got.phase_two_on,
               got.phase_three_on, got.relay_closed, got.converter_stopped,
               got.done_res, got.fault_code);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_status
    res_t got;
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.frequency_command = out_ch.frequency_command;
      got.phase_one_on      = out_ch.phase_one_on;
      got.phase_two_on      = out_ch.phase_two_on;
      got.phase_three_on    = out_ch.phase_three_on;
      got.relay_closed      = out_ch.relay_closed;
      got.converter_stopped = out_ch.converter_stopped;
      got.done_res          = out_ch.done_res;
      got.fault_code        = out_ch.fault_code;
      results_checked++;
      if (status_expected.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = status_expected.pop_front();
        if (got !== want) note_mismatch("status mismatch", want, got);
      end
    end
  end

  // Receiver: random stalls, plus a counted hold-off when one is requested
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Shared driving tasks
  // ---------------------------------------------------------------------------

  // Offers one transaction, with a random idle gap first, and records the
  // expected status once it has been taken.
  task automatic send_item(item_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.voltage_sample <= it.voltage_sample;
    in_ch.current_sample <= it.current_sample;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    status_expected.push_back(predict_status(it));
    items_sent++;
  endtask

  // Sender goes quiet until every outstanding result is back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (status_expected.size() != 0) @(posedge clk);
  endtask

  task automatic set_idling(int send_pct, int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // APB write followed by a read-back of the same register
  task automatic write_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] mask;
    logic [PDATA_W-1:0] readback;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_START_FREQ: begin
        reg_shadow.start_frequency = value[FREQ_W-1:0];
        mask = (1 << FREQ_W) - 1;
      end
      REG_FLOOR_FREQ: begin
        reg_shadow.floor_frequency = value[FREQ_W-1:0];
        mask = (1 << FREQ_W) - 1;
      end
      REG_WIN_LOW: begin
        reg_shadow.window_low = value[CODE_W-1:0];
        mask = (1 << CODE_W) - 1;
      end
      REG_WIN_HIGH: begin
        reg_shadow.window_high = value[CODE_W-1:0];
        mask = (1 << CODE_W) - 1;
      end
      REG_OV_LIMIT: begin
        reg_shadow.overvoltage_limit = value[CODE_W-1:0];
        mask = (1 << CODE_W) - 1;
      end
      REG_OC_LIMIT: begin
        reg_shadow.overcurrent_limit = value[CODE_W-1:0];
        mask = (1 << CODE_W) - 1;
      end
      REG_RAMP_STEP: begin
        reg_shadow.ramp_step = value[STEP_W-1:0];
        mask = (1 << STEP_W) - 1;
      end
      default: begin
        reg_shadow.settle_ticks = value[SETTLE_W-1:0];
        mask = (1 << SETTLE_W) - 1;
      end
    endcase
    reg_writes++;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    readback = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (readback !== (value & mask)) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t register %s read back %h, expected %h",
                 $time, idx.name(), readback, value & mask);
    end
  endtask

  task automatic write_settings(cfg_t s);
    wait_for_results();
    write_register(REG_START_FREQ,   PDATA_W'(s.start_frequency));
    write_register(REG_FLOOR_FREQ,   PDATA_W'(s.floor_frequency));
    write_register(REG_WIN_LOW,      PDATA_W'(s.window_low));
    write_register(REG_WIN_HIGH,     PDATA_W'(s.window_high));
    write_register(REG_OV_LIMIT,     PDATA_W'(s.overvoltage_limit));
    write_register(REG_OC_LIMIT,     PDATA_W'(s.overcurrent_limit));
    write_register(REG_RAMP_STEP,    PDATA_W'(s.ramp_step));
    write_register(REG_SETTLE_TICKS, PDATA_W'(s.settle_ticks));
  endtask

  // ---------------------------------------------------------------------------
  // Sample pickers, driven by the current register settings
  // ---------------------------------------------------------------------------
  function automatic logic [CODE_W-1:0] pick_voltage(bit on_target);
    int lo, hi, ov;
    lo = reg_shadow.window_low;
    hi = reg_shadow.window_high;
    ov = reg_shadow.overvoltage_limit;
    if (on_target && lo <= hi) return CODE_W'($urandom_range(hi, lo));
    if (lo > 0 && (hi >= CODE_MAX || $urandom_range(1)))
      return CODE_W'($urandom_range(lo - 1, 0));
    // above the window, kept at or below the trip level where there is room
    if (hi < CODE_MAX) return CODE_W'($urandom_range(ov > hi ? ov : CODE_MAX, hi + 1));
    return CODE_W'($urandom_range(CODE_MAX, 0));
  endfunction

  function automatic logic [CODE_W-1:0] pick_current();
    return CODE_W'($urandom_range(reg_shadow.overcurrent_limit, 0));
  endfunction

  // Well-formed soft-starts with random content: begin, ticks until the
  // sequence ends (or a cut-off that forces a restart), a few trailing ticks.
  // Some sequences carry a planned trip, some are preceded by a stray tick.
  task automatic run_soft_starts(int budget);
    int sent, ticks, max_ticks, abort_at, hit_pct, ov, oc;
    logic [CODE_W-1:0] v, i;
    sent = 0;
    while (sent < budget) begin
      abort_at  = ($urandom_range(99) < 15) ? int'($urandom_range(260, 1)) : -1;
      hit_pct   = $urandom_range(30);
      max_ticks = ($urandom_range(99) < 15) ? int'($urandom_range(150, 1)) : 320;
      ov = reg_shadow.overvoltage_limit;
      oc = reg_shadow.overcurrent_limit;
      if ($urandom_range(99) < 10) begin
        send_item(item_t'{OP_TICK, CODE_W'($urandom), CODE_W'($urandom)});
        sent++;
      end
      send_item(item_t'{OP_BEGIN, CODE_W'($urandom), CODE_W'($urandom)});
      sent++;
      ticks = 0;
      while (!seq.complete_flag && ticks < max_ticks && sent < budget) begin
        ticks++;
        v = pick_voltage($urandom_range(99) < hit_pct);
        i = pick_current();
        if (ticks == abort_at) begin
          if (ov < CODE_MAX && (oc >= CODE_MAX || $urandom_range(1)))
            v = CODE_W'($urandom_range(CODE_MAX, ov + 1));
          else if (oc < CODE_MAX)
            i = CODE_W'($urandom_range(CODE_MAX, oc + 1));
        end
        send_item(item_t'{OP_TICK, v, i});
        sent++;
      end
      // ticks after the end only report the final status
      if (seq.complete_flag)
        repeat ($urandom_range(3))
          send_item(item_t'{OP_TICK, CODE_W'($urandom), CODE_W'($urandom)});
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Ticks straight after reset: phases two and three still come on at their
  // ticks but the ramp never runs; then a trip before any begin.
  task automatic test_ticks_before_begin();
    set_idling(0, 0);
    repeat (210) send_item(item_t'{OP_TICK, CODE_W'($urandom), CODE_W'($urandom)});
    wait_for_results();
    write_register(REG_OV_LIMIT, 2000);
    send_item(item_t'{OP_TICK, 12'd4095, 12'd0});
    send_item(item_t'{OP_TICK, 12'd0, 12'd0});
  endtask

  // Both operations, sample extremes, limits hit exactly and exceeded, and
  // begin while running and after the end.
  task automatic test_directed_cases();
    set_idling(0, 0);
    write_settings(cfg_t'{start_frequency: 250000, floor_frequency: 240000,
                          window_low: 1000, window_high: 2000,
                          overvoltage_limit: 3000, overcurrent_limit: 3000,
                          ramp_step: 2000, settle_ticks: 2});
    send_item(item_t'{OP_BEGIN, 12'd4095, 12'd4095});  // samples ignored on begin
    send_item(item_t'{OP_TICK,  12'd0,    12'd0});
    send_item(item_t'{OP_TICK,  12'd3000, 12'd3000});  // at both limits, no trip
    send_item(item_t'{OP_BEGIN, 12'd0,    12'd0});     // restart while running
    send_item(item_t'{OP_TICK,  12'd3001, 12'd0});     // overvoltage trip
    send_item(item_t'{OP_TICK,  12'd0,    12'd0});     // done reported only
    send_item(item_t'{OP_BEGIN, 12'd1234, 12'd2345});  // restart after the end
    send_item(item_t'{OP_TICK,  12'd0,    12'd3001});  // overcurrent trip
    send_item(item_t'{OP_TICK,  12'd4095, 12'd4095});
    send_item(item_t'{OP_BEGIN, 12'd2730, 12'd1365});
    send_item(item_t'{OP_TICK,  12'd1500, 12'd100});
    send_item(item_t'{OP_TICK,  12'd2730, 12'd1365});
    send_item(item_t'{OP_TICK,  12'd4095, 12'd4095});  // both over at once
    send_item(item_t'{OP_BEGIN, 12'd0,    12'd4095});
    send_item(item_t'{OP_TICK,  12'd1365, 12'd2730});
  endtask

  // Random settings per idling phase, kept quick to ramp so that decisions
  // come often.
  task automatic test_random_soft_starts();
    int send_pcts[4];
    int stall_pcts[4];
    cfg_t s;
    int start, step, steps, floor_f, lo;
    send_pcts  = '{0, 82, 0, 38};
    stall_pcts = '{0, 0, 82, 38};
    for (int p = 0; p < 4; p++) begin
      start = $urandom_range(400000, 100000);
      step  = $urandom_range(20000, 1);
      steps = $urandom_range(25);
      floor_f = (start > steps * step) ? start - steps * step : 0;
      lo = $urandom_range(3000);
      s.start_frequency   = FREQ_W'(start);
      s.floor_frequency   = FREQ_W'(floor_f);
      s.window_low        = CODE_W'(lo);
      s.window_high       = CODE_W'(($urandom_range(99) < 10) ? lo / 2
                                                             : lo + $urandom_range(800));
      s.overvoltage_limit = CODE_W'($urandom_range(CODE_MAX, 3000));
      s.overcurrent_limit = CODE_W'($urandom_range(CODE_MAX, 2000));
      s.ramp_step         = STEP_W'(step);
      s.settle_ticks      = SETTLE_W'(($urandom_range(99) < 20) ? 50 : $urandom_range(6));
      write_settings(s);
      set_idling(send_pcts[p], stall_pcts[p]);
      run_soft_starts(60);
    end
  endtask

  // Register extremes: floor fault at once, a long ramp in big steps, a
  // frozen ramp that saturates the tick counter, and zero trip limits.
  task automatic test_extreme_settings();
    set_idling(38, 38);
    write_settings(cfg_t'{start_frequency: 20'hFFFFF, floor_frequency: 20'hFFFFF,
                          window_low: 4095, window_high: 0,
                          overvoltage_limit: 4095, overcurrent_limit: 4095,
                          ramp_step: 16'hFFFF, settle_ticks: 0});
    run_soft_starts(40);
    write_settings(cfg_t'{start_frequency: 20'hFFFFF, floor_frequency: 0,
                          window_low: 2048, window_high: 2048,
                          overvoltage_limit: 4095, overcurrent_limit: 4095,
                          ramp_step: 16'hFFFF, settle_ticks: 0});
    run_soft_starts(40);
    write_settings(cfg_t'{start_frequency: 0, floor_frequency: 0,
                          window_low: 4095, window_high: 0,
                          overvoltage_limit: 4095, overcurrent_limit: 4095,
                          ramp_step: 0, settle_ticks: 10'h3FF});
    run_soft_starts(270);
    write_settings(cfg_t'{start_frequency: 1000, floor_frequency: 0,
                          window_low: 0, window_high: 4095,
                          overvoltage_limit: 0, overcurrent_limit: 0,
                          ramp_step: 1, settle_ticks: 0});
    run_soft_starts(20);
  endtask

  // Long receiver hold-off with the sender pushing flat out, then a pause
  // until every result is back before carrying on.
  task automatic test_back_pressure();
    write_settings(cfg_t'{start_frequency: 300000, floor_frequency: 100000,
                          window_low: 1500, window_high: 2500,
                          overvoltage_limit: 4000, overcurrent_limit: 4000,
                          ramp_step: 2000, settle_ticks: 50});
    set_idling(0, 20);
    send_item(item_t'{OP_BEGIN, 12'd0, 12'd0});
    hold_left = HOLD_OFF_CYCLES;
    repeat (40) send_item(item_t'{OP_TICK, pick_voltage(1'b0), pick_current()});
    wait_for_results();
    repeat (40) send_item(item_t'{OP_TICK, pick_voltage(1'b0), pick_current()});
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    in_ch.valid          <= 1'b0;
    in_ch.op             <= OP_TICK;
    in_ch.voltage_sample <= '0;
    in_ch.current_sample <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;

    reg_shadow = cfg_t'{start_frequency: START_FREQ_RST, floor_frequency: FLOOR_FREQ_RST,
                        window_low: WIN_LOW_RST, window_high: WIN_HIGH_RST,
                        overvoltage_limit: OV_LIMIT_RST, overcurrent_limit: OC_LIMIT_RST,
                        ramp_step: RAMP_STEP_RST, settle_ticks: SETTLE_TICKS_RST};
    seq = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_ticks_before_begin();
    test_directed_cases();
    test_random_soft_starts();
    test_extreme_settings();
    test_back_pressure();

    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    mismatches += status_expected.size();

    $display("covered %0d transactions, %0d results checked, %0d register writes",
             items_sent, results_checked, reg_writes);
    $display("sequence endings: %0d contactor closes, %0d trips, %0d floor faults",
             closes_seen, limit_aborts, floor_faults);
    $display("tick counter saturations: %0d", saturations);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #1000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
design/rcss_pkg.sv
design/rcss_if.sv
design/rcss_cfg_regs.sv
design/rcss_seq.sv
design/resonant_converter_soft_start.sv
design/rcss_checker.sv
test/resonant_converter_soft_start_test.sv
